@@ src/pgzr_pkg.sv @@
// Package for the planar gradient predictor with zigzag residual coding.
// Holds payload structs, register and element-size codes, and mask/zigzag helpers.
// No dependencies.
package pgzr_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_ROW_WIDTH      = 2'd0,
    REG_PLANE_ELEMENTS = 2'd1,
    REG_ELEMENT_SIZE   = 2'd2
  } reg_index_e;

  // Element width codes
  typedef enum logic [1:0] {
    ESIZE_8  = 2'd0,
    ESIZE_16 = 2'd1,
    ESIZE_32 = 2'd2,
    ESIZE_64 = 2'd3
  } elem_size_e;

  localparam int unsigned SampleW    = 64;
  localparam int unsigned RowWidthW  = 13;
  localparam int unsigned PlaneElemW = 32;
  localparam int unsigned CfgDataW   = 32;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               stream_end;
  } in_item_t;

  typedef struct packed {
    logic [SampleW-1:0] code;
    logic               block_last;
  } out_item_t;

  // Keep only the low element-width bits
  function automatic logic [SampleW-1:0] elem_mask(elem_size_e size);
    logic [SampleW-1:0] m;
    begin
      unique case (size)
        ESIZE_8:  m = 64'h0000_0000_0000_00FF;
        ESIZE_16: m = 64'h0000_0000_0000_FFFF;
        ESIZE_32: m = 64'h0000_0000_FFFF_FFFF;
        default:  m = '1;
      endcase
      return m;
    end
  endfunction

  // Zigzag map of a residual already reduced to the element width
  function automatic logic [SampleW-1:0] zigzag(logic [SampleW-1:0] r, elem_size_e size);
    logic sign;
    begin
      unique case (size)
        ESIZE_8:  sign = r[7];
        ESIZE_16: sign = r[15];
        ESIZE_32: sign = r[31];
        default:  sign = r[63];
      endcase
      return ({r[SampleW-2:0], 1'b0} ^ {SampleW{sign}}) & elem_mask(size);
    end
  endfunction

endpackage

@@ src/planar_gradient_zigzag_residual.sv @@
// Planar gradient predictor (W + N - NW) with zigzag residual coding.
// Pipeline: an accepted beat passes stage 1, then the output register (two stages).
// Throughput: one sample per cycle; in_ready_o drops only while stage 1 and the
// output register are both full and out_ready_i is low.
// Reset: counters and valids clear, config registers take their reset values; the
// line store is not swept (each entry is written before it is read).
module planar_gradient_zigzag_residual
  import pgzr_pkg::*;
#(
  parameter int unsigned MAX_ROW_WIDTH = 4096,
  parameter int unsigned BLOCK_SIZE    = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // sample channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  // code channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned ColW = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
  localparam int unsigned WW   = ColW + 1;
  localparam int unsigned BpW  = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [RowWidthW-1:0]  row_width_q;
  logic [PlaneElemW-1:0] plane_elements_q;
  elem_size_e            element_size_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q      <= RowWidthW'(1);
      plane_elements_q <= PlaneElemW'(1);
      element_size_q   <= ESIZE_8;
    end else if (cfg_valid_i) begin
      unique case (reg_index_e'(cfg_index_i))
        REG_ROW_WIDTH:      row_width_q      <= cfg_data_i[RowWidthW-1:0];
        REG_PLANE_ELEMENTS: plane_elements_q <= cfg_data_i[PlaneElemW-1:0];
        REG_ELEMENT_SIZE:   element_size_q   <= elem_size_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  // Effective row width: zero counts as one, saturate at the store depth
  logic [WW-1:0] eff_width;
  logic [31:0]   row_ext;
  assign row_ext = 32'(row_width_q);

  always_comb begin
    if (row_width_q == '0) begin
      eff_width = WW'(1);
    end else if (row_ext > 32'(MAX_ROW_WIDTH)) begin
      eff_width = WW'(MAX_ROW_WIDTH);
    end else begin
      eff_width = WW'(row_width_q);
    end
  end

  // ---------------------------------------------------------------
  // Handshake and pipeline control
  // ---------------------------------------------------------------
  logic s1_valid_q, s1_go, in_accept, out_valid_q;

  assign s1_go      = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_go;
  assign in_accept  = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------
  // Position counters (advance at accept)
  // ---------------------------------------------------------------
  logic [ColW-1:0]       col_q, col_d;
  logic                  first_done_q, first_done_d;
  logic [PlaneElemW-1:0] plane_pos_q, plane_pos_d;
  logic [BpW-1:0]        block_pos_q, block_pos_d;
  logic [WW-1:0]         col_inc;
  logic [PlaneElemW-1:0] plane_inc;
  logic                  blast;

  assign col_inc   = {1'b0, col_q} + WW'(1);
  assign plane_inc = plane_pos_q + PlaneElemW'(1);
  assign blast     = in_data_i.stream_end || (block_pos_q == BpW'(BLOCK_SIZE - 1));

  always_comb begin
    col_d        = col_q;
    first_done_d = first_done_q;
    plane_pos_d  = plane_pos_q;
    block_pos_d  = block_pos_q;
    if (in_accept) begin
      // column wrap ends a row
      if (col_inc >= eff_width) begin
        col_d        = '0;
        first_done_d = 1'b1;
      end else begin
        col_d = col_inc[ColW-1:0];
      end
      // plane wrap restarts at the first row
      plane_pos_d = plane_inc;
      if (plane_inc == plane_elements_q) begin
        plane_pos_d  = '0;
        col_d        = '0;
        first_done_d = 1'b0;
      end
      block_pos_d = blast ? '0 : block_pos_q + BpW'(1);
      // end of stream clears the position
      if (in_data_i.stream_end) begin
        col_d        = '0;
        first_done_d = 1'b0;
        plane_pos_d  = '0;
        block_pos_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      first_done_q <= 1'b0;
      plane_pos_q  <= '0;
      block_pos_q  <= '0;
    end else begin
      col_q        <= col_d;
      first_done_q <= first_done_d;
      plane_pos_q  <= plane_pos_d;
      block_pos_q  <= block_pos_d;
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: sample in flight, line store read data
  // ---------------------------------------------------------------
  logic [SampleW-1:0] s1_sample_q;
  logic               s1_blast_q;
  logic [ColW-1:0]    s1_col_q;
  logic               s1_col_nz_q;
  logic               s1_north_q;
  logic               fwd_q;
  logic [SampleW-1:0] fwd_data_q;
  logic [SampleW-1:0] rd_data_q;
  logic               fwd_d;

  // same column written by the leaving item at the edge it is read
  assign fwd_d = s1_valid_q && s1_go && (s1_col_q == col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_sample_q <= in_data_i.sample & elem_mask(element_size_q);
      s1_blast_q  <= blast;
      s1_col_q    <= col_q;
      s1_col_nz_q <= (col_q != '0);
      s1_north_q  <= first_done_q;
      fwd_q       <= fwd_d;
      fwd_data_q  <= s1_sample_q;
    end
  end

  // Line store: read at accept, written as stage 1 leaves
  logic [SampleW-1:0] line_mem [MAX_ROW_WIDTH];

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rd_data_q <= line_mem[col_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_go) begin
      line_mem[s1_col_q] <= s1_sample_q;
    end
  end

  // ---------------------------------------------------------------
  // Prediction, residual and zigzag
  // ---------------------------------------------------------------
  logic [SampleW-1:0] west_q, nw_q;
  logic [SampleW-1:0] above, w_val, n_val, nw_val, resid;

  assign above  = fwd_q ? fwd_data_q : rd_data_q;
  assign w_val  = s1_col_nz_q ? west_q : '0;
  assign n_val  = s1_north_q ? above : '0;
  assign nw_val = (s1_north_q && s1_col_nz_q) ? nw_q : '0;
  assign resid  = (s1_sample_q - w_val - n_val + nw_val) & elem_mask(element_size_q);

  // neighbors from the previous sample
  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_go) begin
      west_q <= s1_sample_q;
      nw_q   <= above;
    end
  end

  // ---------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------
  out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_valid_q) begin
      out_q.code       <= zigzag(resid, element_size_q);
      out_q.block_last <= s1_blast_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_valid_q)
    else $error("accepted beat did not enter stage 1");

  a_ready_low_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a full pipeline");

  a_stall_holds_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |=> (s1_valid_q && $stable(s1_col_q)))
    else $error("stage 1 changed while the output stalled");

  a_advance_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_go) |=> out_valid_q)
    else $error("stage 1 advanced without a result");

endmodule
